@@ hdl/aes_pkg.sv @@
// Package with shared types, constants and AES helper functions.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned NumRounds  = 10;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned RoundCntW  = 4;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CTR = 2'd2,
    MODE_RSV = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_MODE     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_ECB  = 2'd0,
    OP_CBC  = 2'd1,
    OP_CTR  = 2'd2,
    OP_FAIL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } core_state_e;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        final_block;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        result_last;
    logic        status;
  } out_req_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_e          op;
    logic [127:0] data;
    logic [15:0]  byte_mask;
    logic         restart;
    logic         last;
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block; byte 0 is the most significant.
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int unsigned i);
    return v[127 - 8*i -: 8];
  endfunction

  // One round of the key schedule.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and, unless it is the last round, MixColumns.
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[j + 4*c] = sbox(get_byte(s, j + 4*((c + j) % 4)));
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = t[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/aes_front.sv @@
// Front end: accepts input requests, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module aes_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire aes_pkg::in_req_t in_req_i,
  input  wire aes_pkg::mode_e   mode_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output aes_pkg::cmd_t         cmd_o
);
  import aes_pkg::*;

  // Two-entry command queue.
  cmd_t        mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        start_q;
  cmd_t        cmd;
  logic [4:0]  count;
  logic        do_push, do_pop;

  always_comb begin
    count = (in_req_i.byte_count > 5'(BlockBytes)) ? 5'(BlockBytes) : in_req_i.byte_count;
    cmd.data      = {in_req_i.block_high, in_req_i.block_low};
    cmd.restart   = start_q;
    cmd.last      = in_req_i.final_block;
    for (int i = 0; i < 16; i++) begin
      cmd.byte_mask[15 - i] = (5'(i) < count);
    end
    unique case (mode_i)
      MODE_CTR: cmd.op = OP_CTR;
      MODE_CBC: cmd.op = (count == 5'(BlockBytes)) ? OP_CBC : OP_FAIL;
      default:  cmd.op = (count == 5'(BlockBytes)) ? OP_ECB : OP_FAIL;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      start_q  <= 1'b1;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
        start_q  <= in_req_i.final_block;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

@@ hdl/aes_core.sv @@
// Back end: iterative AES-128 round engine with chain state and result register.
`timescale 1ns / 1ps
`default_nettype none
module aes_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire aes_pkg::cmd_t      cmd_i,
  input  wire logic [127:0]       key_i,
  input  wire logic [127:0]       iv_i,
  output logic                    empty,
  input  wire logic               pop,
  output aes_pkg::out_req_t       out_req_o
);
  import aes_pkg::*;

  core_state_e              state_q, state_d;
  logic [127:0]             st_q, st_d;
  logic [127:0]             rk_q, rk_d;
  logic [127:0]             chain_q, chain_d;
  logic [7:0]               rc_q, rc_d;
  logic [RoundCntW-1:0]     rnd_q, rnd_d;
  cmd_t                     cur_q, cur_d;
  out_req_t                 res_q, res_d;
  logic                     full_q, full_d;
  logic [127:0]             chain_in, aes_in, nk, ct, masked;
  logic [127:0]             mask;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8*i -: 8] = {8{cur_q.byte_mask[15 - i]}};
    end
  end

  assign chain_in = cmd_i.restart ? iv_i : chain_q;
  assign nk       = next_key(rk_q, rc_q);
  assign ct       = round_fn(st_q, rnd_q == RoundCntW'(NumRounds)) ^ nk;
  // In the done state st_q holds the finished keystream block.
  assign masked   = (st_q ^ cur_q.data) & mask;
  assign empty    = !full_q;
  assign out_req_o = res_q;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    rk_d        = rk_q;
    rc_d        = rc_q;
    rnd_d       = rnd_q;
    cur_d       = cur_q;
    chain_d     = chain_q;
    res_d       = res_q;
    full_d      = full_q;
    cmd_ready_o = 1'b0;
    aes_in      = cmd_i.data;
    if (pop && full_q) begin
      full_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          case (cmd_i.op)
            OP_CTR: aes_in = chain_in;
            OP_CBC: aes_in = cmd_i.data ^ chain_in;
            default: aes_in = cmd_i.data;
          endcase
          if (cmd_i.op == OP_CTR) begin
            chain_d = chain_in + 128'd1;
          end else if (cmd_i.restart) begin
            chain_d = iv_i;
          end
          st_d  = aes_in ^ key_i;
          rk_d  = key_i;
          rc_d  = 8'h01;
          rnd_d = RoundCntW'(1);
          state_d = (cmd_i.op == OP_FAIL) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        st_d  = ct;
        rk_d  = nk;
        rc_d  = xtime(rc_q);
        rnd_d = rnd_q + RoundCntW'(1);
        if (rnd_q == RoundCntW'(NumRounds)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!full_d) begin
          full_d = 1'b1;
          res_d.result_last = cur_q.last;
          res_d.status      = (cur_q.op == OP_FAIL);
          case (cur_q.op)
            OP_FAIL: {res_d.result_high, res_d.result_low} = '0;
            OP_CTR:  {res_d.result_high, res_d.result_low} = masked;
            default: {res_d.result_high, res_d.result_low} = st_q;
          endcase
          if (cur_q.op == OP_CBC) begin
            chain_d = st_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    rk_q  <= rk_d;
    cur_q <= cur_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rc_q    <= 8'h01;
      rnd_q   <= '0;
      chain_q <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
      full_q  <= full_d;
    end
  end
endmodule
`default_nettype wire

@@ hdl/aes128_mode_engine.sv @@
// Top level of the AES-128 ECB, CBC and CTR encryption engine.
`timescale 1ns / 1ps
`default_nettype none
// The block looks like a queue on both sides. A request is pushed with push while
// full is low; it carries one 16-byte block, its valid byte count and a final mark.
// Results come out in order: while empty is low the oldest result is on out_req_o,
// and pop takes it. Key, IV and mode are written through the plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i) while the engine is idle; the user must keep to
// this, as the block does not enforce it. The front end classifies each request
// (mode, short block error, message start) and places it in a two-entry command
// queue. The back end runs one AES round per cycle with an on-the-fly key schedule:
// a request goes from the queue through load, ten rounds and write-back to the
// result register; short-block errors in ECB or CBC skip the rounds. The single
// round unit takes a new block only after writing back the last. The result
// register lets the back end finish the next block while a result waits; when the
// receiver stalls, the back end holds its finished block, then the queue fills and
// full rises. Reset empties the queue, zeroes key, IV, mode and chain value, and
// marks the next request as a message start, so its chain is loaded from the IV.
module aes128_mode_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire aes_pkg::in_req_t              in_req_i,
  output logic                               empty,
  input  wire logic                          pop,
  output aes_pkg::out_req_t                  out_req_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [aes_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [aes_pkg::CfgDataW-1:0]  cfg_data_i
);
  import aes_pkg::*;

  logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
  mode_e       mode_q;
  cmd_t        cmd;
  logic        cmd_valid, cmd_ready;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      mode_q     <= MODE_ECB;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_IV_HIGH:  iv_high_q  <= cfg_data_i;
        REG_IV_LOW:   iv_low_q   <= cfg_data_i;
        REG_MODE:     mode_q     <= mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  aes_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_req_i    (in_req_i),
    .mode_i      (mode_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  aes_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .key_i       ({key_high_q, key_low_q}),
    .iv_i        ({iv_high_q, iv_low_q}),
    .empty       (empty),
    .pop         (pop),
    .out_req_o   (out_req_o)
  );
endmodule
`default_nettype wire
